FILE: hw/rtl/asid_command_register_unpacker_top_defines.svh
// Assertion macros used by the ASID unpacker top level.
`ifndef ASID_COMMAND_REGISTER_UNPACKER_TOP_DEFINES_SVH
`define ASID_COMMAND_REGISTER_UNPACKER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define ASIDU_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("asidu same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst is high.
`define ASIDU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("asidu next-cycle check failed");

`endif

FILE: hw/rtl/asidu_pkg.sv
// Package: types, constants and the slot remap table of the ASID unpacker.
`default_nettype none
package asidu_pkg;

  localparam int REGISTER_SLOTS = 28;
  localparam int HEADER_BYTES   = 8;
  localparam int BYTE_BITS      = 7;
  localparam int ADDR_BITS      = 5;
  localparam int DATA_BITS      = 8;
  localparam int POS_BITS       = 4;

  typedef logic [REGISTER_SLOTS-1:0] slot_vec_t;
  typedef logic [ADDR_BITS-1:0]      sid_addr_t;

  // Slot to SID register address.
  localparam sid_addr_t SLOT_TO_SID [REGISTER_SLOTS] = '{
    5'h00, 5'h01, 5'h02, 5'h03, 5'h05, 5'h06, 5'h07, 5'h08, 5'h09, 5'h0a,
    5'h0c, 5'h0d, 5'h0e, 5'h0f, 5'h10, 5'h11, 5'h13, 5'h14, 5'h15, 5'h16,
    5'h17, 5'h18, 5'h04, 5'h0b, 5'h12, 5'h04, 5'h0b, 5'h12
  };

  // Contents of the input register.
  typedef struct packed {
    logic                 valid;
    logic [BYTE_BITS-1:0] payload_byte;
    logic                 first_of_message;
  } in_stage_t;

  // Decoded register write handed to the result register.
  typedef struct packed {
    logic                 valid;
    sid_addr_t            sid_address;
    logic [DATA_BITS-1:0] sid_data;
  } wr_stage_t;

endpackage
`default_nettype wire

FILE: hw/rtl/asidu_if.sv
// Valid/ready channel interfaces: command bytes in, SID register writes out.
`default_nettype none
interface asidu_cmd_if
  import asidu_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [BYTE_BITS-1:0] payload_byte;
  logic                 first_of_message;

  modport source (output valid, output payload_byte, output first_of_message, input ready);
  modport sink   (input valid, input payload_byte, input first_of_message, output ready);
endinterface

interface asidu_wr_if
  import asidu_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [ADDR_BITS-1:0] sid_address;
  logic [DATA_BITS-1:0] sid_data;

  modport source (output valid, output sid_address, output sid_data, input ready);
  modport sink   (input valid, input sid_address, input sid_data, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/asidu_in_reg.sv
// Input register: holds one command byte until the decoder consumes it.
`default_nettype none
module asidu_in_reg
  import asidu_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  asidu_cmd_if.sink   cmd,
  input  wire logic   go,
  output in_stage_t   stage
);

  in_stage_t stage_q;

  assign cmd.ready = !stage_q.valid || go;
  assign stage     = stage_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_q.valid <= 1'b0;
    end else if (cmd.valid && cmd.ready) begin
      stage_q.valid <= 1'b1;
    end else if (go) begin
      stage_q.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      stage_q.payload_byte     <= cmd.payload_byte;
      stage_q.first_of_message <= cmd.first_of_message;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/asidu_decode.sv
// Header/mask state + slot decode: one byte per unstalled cycle, optional write.
`default_nettype none
module asidu_decode
  import asidu_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire in_stage_t stage,
  input  wire logic      load_ok,
  output logic           go,
  output wr_stage_t      wr
);

  slot_vec_t             pending_mask, pending_mask_next;
  slot_vec_t             top_bits, top_bits_next;
  logic [POS_BITS-1:0]   header_position, header_position_next;

  slot_vec_t             mask_eff, top_eff, field, lowest;
  logic [POS_BITS-1:0]   pos_eff;
  logic [2:0]            pos;
  logic                  in_header;
  sid_addr_t             addr;
  logic                  top_bit;

  always_comb begin
    // A first-byte marker restarts the header.
    mask_eff  = stage.first_of_message ? '0 : pending_mask;
    top_eff   = stage.first_of_message ? '0 : top_bits;
    pos_eff   = stage.first_of_message ? '0 : header_position;
    in_header = pos_eff < POS_BITS'(HEADER_BYTES);
    pos       = pos_eff[2:0];

    case (pos[1:0])
      2'd0:    field = {21'd0, stage.payload_byte};
      2'd1:    field = {14'd0, stage.payload_byte, 7'd0};
      2'd2:    field = {7'd0, stage.payload_byte, 14'd0};
      default: field = {stage.payload_byte, 21'd0};
    endcase

    // Lowest pending slot, one-hot.
    lowest  = mask_eff & (~mask_eff + slot_vec_t'(1));
    addr    = '0;
    for (int i = 0; i < REGISTER_SLOTS; i++) begin
      addr = addr | (lowest[i] ? SLOT_TO_SID[i] : '0);
    end
    top_bit = |(top_eff & lowest);

    pending_mask_next    = mask_eff;
    top_bits_next        = top_eff;
    header_position_next = pos_eff;
    wr.valid             = 1'b0;
    wr.sid_address       = addr;
    wr.sid_data          = {top_bit, stage.payload_byte};

    if (in_header) begin
      if (!pos[2]) begin
        pending_mask_next = mask_eff | field;
      end else begin
        top_bits_next = top_eff | field;
      end
      header_position_next = {1'b0, pos} + POS_BITS'(1);
    end else if (|mask_eff) begin
      wr.valid          = stage.valid;
      pending_mask_next = mask_eff & ~lowest;
    end

    go = stage.valid && (!wr.valid || load_ok);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_mask    <= '0;
      top_bits        <= '0;
      header_position <= POS_BITS'(HEADER_BYTES);
    end else if (go) begin
      pending_mask    <= pending_mask_next;
      top_bits        <= top_bits_next;
      header_position <= header_position_next;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/asidu_out_reg.sv
// Result register driving the SID write channel.
`default_nettype none
module asidu_out_reg
  import asidu_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire wr_stage_t wr,
  input  wire logic      go,
  output logic           load_ok,
  asidu_wr_if.source     wr_out
);

  logic                 valid;
  sid_addr_t            sid_address;
  logic [DATA_BITS-1:0] sid_data;
  logic                 load;

  assign load_ok            = !valid || wr_out.ready;
  assign load               = go && wr.valid;
  assign wr_out.valid       = valid;
  assign wr_out.sid_address = sid_address;
  assign wr_out.sid_data    = sid_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (wr_out.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sid_address <= wr.sid_address;
      sid_data    <= wr.sid_data;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/asid_command_register_unpacker_top.sv
// Top level of the ASID command register unpacker.
//
// cmd (sink): one 7-bit payload byte per beat, first_of_message set on the
//   first byte of each command message. Bytes 0..3 load the 28-bit slot
//   mask, bytes 4..7 the matching bit-7 flags; later bytes are data.
// wr (source): one SID register write per beat, sid_address from the slot
//   remap table and sid_data with its bit 7 restored. Header bytes and data
//   bytes beyond the last set mask bit produce no beat.
// Path: a byte accepted on cmd sits in the input register, decode runs
//   on it, and its write is loaded into the result register, which drives
//   wr.
// Throughput: one byte per cycle while no write is held off by wr. The
//   decode path is a 28-bit lowest-set-bit search plus the remap table lookup, all combinational.
// Reset (rst, synchronous): both pipeline registers empty, mask and flags
//   cleared, header marked complete, so data before any message is dropped.
// Stall: while wr is held off the result register keeps its write; the
//   input register keeps taking bytes that make no write, and cmd.ready
//   drops only when a pending write finds the result register full.
`default_nettype none
`include "asid_command_register_unpacker_top_defines.svh"
module asid_command_register_unpacker_top
  import asidu_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  asidu_cmd_if.sink  cmd,
  asidu_wr_if.source wr
);

  in_stage_t stage;
  wr_stage_t dec_wr;
  logic      go;
  logic      load_ok;

  asidu_in_reg u_in_reg (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd),
    .go    (go),
    .stage (stage)
  );

  asidu_decode u_decode (
    .clk     (clk),
    .rst     (rst),
    .stage   (stage),
    .load_ok (load_ok),
    .go      (go),
    .wr      (dec_wr)
  );

  asidu_out_reg u_out_reg (
    .clk     (clk),
    .rst     (rst),
    .wr      (dec_wr),
    .go      (go),
    .load_ok (load_ok),
    .wr_out  (wr)
  );

  // A decoded write only exists for a held byte.
  `ASIDU_ASSERT_NOW(a_wr_needs_byte, dec_wr.valid, stage.valid)
  // A new byte enters a full input register only as the old one leaves.
  `ASIDU_ASSERT_NOW(a_no_overwrite, cmd.valid && cmd.ready && stage.valid, go)
  // A consumed write shows up on the output next cycle.
  `ASIDU_ASSERT_NEXT(a_wr_lands, go && dec_wr.valid, wr.valid)
  // Remap table only holds real SID register addresses.
  `ASIDU_ASSERT_NOW(a_addr_range, dec_wr.valid, dec_wr.sid_address <= 5'd24)

endmodule
`default_nettype wire
